### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define LR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lr_pkg.sv
// Shared types and constants of the line rasterizer.
package lr_pkg;

    // Item kind, as carried on the input and through the command queue.
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    // Guard bits of the error term above the coordinate width.
    localparam int ERR_EXTRA_BITS = 3;

    // Status of the back end, seen by the top level.
    typedef struct packed {
        logic active;   // a line is in progress
        logic consume;  // a command leaves the queue this cycle
        logic emit;     // the command produces a pixel
        logic drop;     // the command is a step with no line in progress
    } t_back_stat;

endpackage

### rtl/core/lr_if.sv
// Valid/ready channel interfaces of the line rasterizer.
interface lr_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

interface lr_cmd_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/lr_queue.sv
// Small register FIFO between the front and back ends.
module lr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lr_cmd_if.sink    i_push,
    lr_cmd_if.source  o_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign i_push.ready = (r_count != CNT_FULL);
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.data   = r_mem[r_rd];

    assign push = i_push.valid && i_push.ready;
    assign pop  = o_pop.valid && o_pop.ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

endmodule

### rtl/core/lr_front.sv
// Front end: accept items, classify them and precompute line setup.
module lr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lr_in_if.sink     i_in,
    lr_cmd_if.source  o_cmd
);
    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS + lr_pkg::ERR_EXTRA_BITS;

    typedef struct packed {
        lr_pkg::t_action        kind;
        logic [CB-1:0]          sx;
        logic [CB-1:0]          sy;
        logic [CB-1:0]          major;
        logic                   x_major;
        logic                   x_neg;
        logic                   y_neg;
        logic signed [EW-1:0]   err;
        logic signed [EW-1:0]   inc_move;
        logic signed [EW-1:0]   inc_stay;
    } t_cmd;

    logic          r_valid, n_valid;
    t_cmd          r_cmd, n_cmd;
    logic          accept;
    logic          x_up, y_up, x_maj;
    logic [CB-1:0] dx, dy, major, minor;
    logic [EW-1:0] minor2, major2, major1;

    assign i_in.ready  = !r_valid || o_cmd.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd.valid = r_valid;
    assign o_cmd.data  = r_cmd;

    // Deltas, directions and major axis; ties go to y.
    always_comb begin
        x_up   = i_in.end_x > i_in.start_x;
        y_up   = i_in.end_y > i_in.start_y;
        dx     = x_up ? i_in.end_x - i_in.start_x : i_in.start_x - i_in.end_x;
        dy     = y_up ? i_in.end_y - i_in.start_y : i_in.start_y - i_in.end_y;
        x_maj  = dx > dy;
        major  = x_maj ? dx : dy;
        minor  = x_maj ? dy : dx;
        minor2 = {2'b00, minor, 1'b0};
        major2 = {2'b00, major, 1'b0};
        major1 = {3'b000, major};

        n_cmd.kind     = lr_pkg::t_action'(i_in.action);
        n_cmd.sx       = i_in.start_x;
        n_cmd.sy       = i_in.start_y;
        n_cmd.major    = major;
        n_cmd.x_major  = x_maj;
        n_cmd.x_neg    = !x_up;
        n_cmd.y_neg    = !y_up;
        n_cmd.err      = $signed(minor2 - major1);
        n_cmd.inc_move = $signed(minor2 - major2);
        n_cmd.inc_stay = $signed(minor2);
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_cmd.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### rtl/core/lr_back.sv
// Back end: hold the line state, walk pixels and register the result.
module lr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lr_cmd_if.sink              i_cmd,
    lr_out_if.source            o_out,
    output lr_pkg::t_back_stat  o_stat
);
    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS + lr_pkg::ERR_EXTRA_BITS;
    localparam logic [CB-1:0] ONE = CB'(1);

    typedef struct packed {
        lr_pkg::t_action        kind;
        logic [CB-1:0]          sx;
        logic [CB-1:0]          sy;
        logic [CB-1:0]          major;
        logic                   x_major;
        logic                   x_neg;
        logic                   y_neg;
        logic signed [EW-1:0]   err;
        logic signed [EW-1:0]   inc_move;
        logic signed [EW-1:0]   inc_stay;
    } t_cmd;

    t_cmd                 cmd;
    logic                 r_active;
    logic [CB-1:0]        r_x, r_y, r_rem;
    logic                 r_x_major, r_x_neg, r_y_neg;
    logic signed [EW-1:0] r_err, r_inc_move, r_inc_stay;
    logic                 r_out_valid, r_last;
    logic [CB-1:0]        r_px, r_py;

    logic                 pop, is_load, emit, drop, minor_moves;
    logic                 mv_x, mv_y;
    logic [CB-1:0]        n_x, n_y, n_rem;
    logic signed [EW-1:0] n_err;

    assign cmd = t_cmd'(i_cmd.data);

    assign pop     = i_cmd.valid && (!r_out_valid || o_out.ready);
    assign is_load = (cmd.kind == lr_pkg::ACT_LOAD);
    assign emit    = pop && (is_load || r_active);
    assign drop    = pop && !is_load && !r_active;

    assign i_cmd.ready = !r_out_valid || o_out.ready;

    // One step: major axis always moves, minor when the error is not negative.
    always_comb begin
        minor_moves = !r_err[EW-1];
        n_err       = r_err + (minor_moves ? r_inc_move : r_inc_stay);
        mv_x        = r_x_major || minor_moves;
        mv_y        = !r_x_major || minor_moves;
        n_x         = mv_x ? (r_x_neg ? r_x - ONE : r_x + ONE) : r_x;
        n_y         = mv_y ? (r_y_neg ? r_y - ONE : r_y + ONE) : r_y;
        n_rem       = r_rem - ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop && is_load) begin
                r_active <= (cmd.major != '0);
            end else if (emit) begin
                r_active <= (n_rem != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && is_load) begin
            r_x        <= cmd.sx;
            r_y        <= cmd.sy;
            r_rem      <= cmd.major;
            r_x_major  <= cmd.x_major;
            r_x_neg    <= cmd.x_neg;
            r_y_neg    <= cmd.y_neg;
            r_err      <= cmd.err;
            r_inc_move <= cmd.inc_move;
            r_inc_stay <= cmd.inc_stay;
            r_px       <= cmd.sx;
            r_py       <= cmd.sy;
            r_last     <= (cmd.major == '0);
        end else if (emit) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_rem  <= n_rem;
            r_err  <= n_err;
            r_px   <= n_x;
            r_py   <= n_y;
            r_last <= (n_rem == '0);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_x    = r_px;
    assign o_out.pixel_y    = r_py;
    assign o_out.last_pixel = r_last;

    assign o_stat.active  = r_active;
    assign o_stat.consume = pop;
    assign o_stat.emit    = emit;
    assign o_stat.drop    = drop;

endmodule

### rtl/core/line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer.
//
// Bresenham line rasterizer for all eight octants. A load beat (action 0)
// brings two endpoints and produces the start pixel; each step beat
// (action 1) then produces the next pixel of that line, and the final
// endpoint comes out with last_pixel set. When both deltas are equal the
// y axis is the major axis. A step beat with no line in progress produces
// nothing, and a load beat in the middle of a line drops the old line.
// Throughput is one beat per clock on both sides while the output does
// not stall: the front end takes a new beat every cycle unless stalled,
// and the back end retires one command per cycle unless the output
// stalls, bound by its combinational error-term add. An accepted input
// beat reaches the output as a pixel through the front register, a queue
// entry and the output register. A stall on the output fills the two-entry
// queue and then the front register before the input sees ready drop.
`include "assert_macros.svh"

module line_rasterizer_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lr_in_if.sink    i_in,
    lr_out_if.source o_out
);
    // Command word: kind, start x/y, major delta, three flags, three error terms.
    localparam int EW    = COORD_BITS + lr_pkg::ERR_EXTRA_BITS;
    localparam int CMD_W = 1 + 3 * COORD_BITS + 3 + 3 * EW;

    lr_cmd_if #(.W(CMD_W)) cmd_front ();
    lr_cmd_if #(.W(CMD_W)) cmd_back ();

    lr_pkg::t_back_stat stat;

    // Classify beats and precompute deltas, directions and error terms.
    lr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (cmd_front)
    );

    // Decouple the front end from output stalls.
    lr_queue #(
        .W     (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_front),
        .o_pop   (cmd_back)
    );

    // Walk the line and register each pixel.
    lr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_back),
        .o_out   (o_out),
        .o_stat  (stat)
    );

    // A command that produces a pixel shows it on the output next cycle.
    `LR_ASSERT_NXT(a_emit_shows, stat.emit, o_out.valid, "emitted pixel missing on output")
    // The last-pixel flag agrees with whether the line is still running.
    `LR_ASSERT_NXT(a_last_vs_active, stat.emit, o_out.last_pixel == !stat.active, "bad last flag")
    // Hold the queue while a result waits on the output.
    `LR_ASSERT_IMP(a_no_pop_stalled, o_out.valid && !o_out.ready, !stat.consume, "command consumed while output stalled")
    // A step dropped for lack of a line never produces a pixel.
    `LR_ASSERT_IMP(a_drop_no_emit, stat.drop, !stat.emit, "dropped step produced a pixel")

endmodule
